[rtl/chacha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, types and helpers for the ChaCha20 block pipeline.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int STEPS_PER_DR  = 8;
  localparam int NUM_CELLS     = DOUBLE_ROUNDS * STEPS_PER_DR;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d36, 32'h3320646e, 32'h61707865
  };

  // rotate amounts of the four quarter-round steps
  localparam logic [3:0][4:0] ROT = {5'd7, 5'd8, 5'd12, 5'd16};

  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_KEY01   = 3'd0,
    REG_KEY23   = 3'd1,
    REG_KEY45   = 3'd2,
    REG_KEY67   = 3'd3,
    REG_NONCE01 = 3'd4,
    REG_NONCE2  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic [15:0][31:0] w;
    logic [31:0]       ctr;
    logic [7:0][63:0]  msg;
  } stage_t;

  function automatic logic [15:0][31:0] init_state(cfg_t cfg, logic [31:0] ctr);
    logic [15:0][31:0] s;
    s[3:0]   = SIGMA;
    s[11:4]  = cfg.key;
    s[12]    = ctr;
    s[15:13] = cfg.nonce;
    return s;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

endpackage

[rtl/chacha_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_cell
// One quarter-round step on all four lanes (column or diagonal), registered.
// phase[2] selects diagonal, phase[1:0] the step within the quarter round.
// ----------------------------------------------------------------------------
module chacha_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [2:0]          phase,
  input  logic                in_valid,
  input  chacha_pkg::stage_t  in_data,
  output logic                out_valid,
  output chacha_pkg::stage_t  out_data
);

  logic [15:0][31:0] w_next;

  always_comb begin
    logic [31:0] a, b, c, d;
    logic [3:0]  ia, ib, ic, id;
    logic [1:0]  col;
    w_next = in_data.w;
    for (int j = 0; j < 4; j++) begin
      col = 2'(j);
      ia  = {2'd0, col};
      ib  = {2'd1, 2'(col + (phase[2] ? 2'd1 : 2'd0))};
      ic  = {2'd2, 2'(col + (phase[2] ? 2'd2 : 2'd0))};
      id  = {2'd3, 2'(col + (phase[2] ? 2'd3 : 2'd0))};
      a = in_data.w[ia];
      b = in_data.w[ib];
      c = in_data.w[ic];
      d = in_data.w[id];
      if (!phase[0]) begin
        a = a + b;
        d = chacha_pkg::rotl(d ^ a, chacha_pkg::ROT[phase[1:0]]);
      end else begin
        c = c + d;
        b = chacha_pkg::rotl(b ^ c, chacha_pkg::ROT[phase[1:0]]);
      end
      w_next[ia] = a;
      w_next[ib] = b;
      w_next[ic] = c;
      w_next[id] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.w   <= w_next;
      out_data.ctr <= in_data.ctr;
      out_data.msg <= in_data.msg;
    end
  end

endmodule

[rtl/chacha_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_out
// Feed-forward add of the initial state, XOR with the message, output register.
// ----------------------------------------------------------------------------
module chacha_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  chacha_pkg::cfg_t    cfg,
  input  logic                in_valid,
  input  chacha_pkg::stage_t  in_data,
  output logic                out_valid,
  output logic [511:0]        out_data
);

  logic [15:0][31:0] init;
  logic [15:0][31:0] ks;

  always_comb begin
    init = chacha_pkg::init_state(cfg, in_data.ctr);
    for (int i = 0; i < 16; i++) begin
      ks[i] = in_data.w[i] + init[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= in_data.msg ^ ks;
    end
  end

endmodule

[rtl/chacha20_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_block_cipher
// ChaCha20 (RFC 8439) block encrypt/decrypt: a chain of quarter-round cells.
// One cell per quarter-round step, then the output register.
// Throughput: one 64-byte item per cycle; a held output stalls the whole chain.
// Reset: clears all valid bits and the key and nonce registers to zero.
// ----------------------------------------------------------------------------
module chacha20_block_cipher (
  input  logic                              clk,
  input  logic                              rst,
  // apb
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chacha_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                       pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [543:0]                      s_tdata,  // block_counter, message_0..7
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [511:0]                      m_tdata   // cipher_0..7
);

  logic [63:0] key01, key23, key45, key67, nonce01;
  logic [31:0] nonce2;
  chacha_pkg::cfg_t cfg;
  chacha_pkg::reg_idx_t idx;

  logic en;
  logic [chacha_pkg::NUM_CELLS:0] stage_v;
  chacha_pkg::stage_t stage_d [chacha_pkg::NUM_CELLS+1];

  assign pready = 1'b1;
  assign idx    = chacha_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key01   <= '0;
      key23   <= '0;
      key45   <= '0;
      key67   <= '0;
      nonce01 <= '0;
      nonce2  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        chacha_pkg::REG_KEY01:   key01   <= pwdata;
        chacha_pkg::REG_KEY23:   key23   <= pwdata;
        chacha_pkg::REG_KEY45:   key45   <= pwdata;
        chacha_pkg::REG_KEY67:   key67   <= pwdata;
        chacha_pkg::REG_NONCE01: nonce01 <= pwdata;
        chacha_pkg::REG_NONCE2:  nonce2  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      chacha_pkg::REG_KEY01:   prdata = key01;
      chacha_pkg::REG_KEY23:   prdata = key23;
      chacha_pkg::REG_KEY45:   prdata = key45;
      chacha_pkg::REG_KEY67:   prdata = key67;
      chacha_pkg::REG_NONCE01: prdata = nonce01;
      chacha_pkg::REG_NONCE2:  prdata = {32'd0, nonce2};
      default:                 prdata = '0;
    endcase
  end

  assign cfg.key   = {key67, key45, key23, key01};
  assign cfg.nonce = {nonce2, nonce01};

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign stage_v[0]     = s_tvalid;
  assign stage_d[0].w   = chacha_pkg::init_state(cfg, s_tdata[31:0]);
  assign stage_d[0].ctr = s_tdata[31:0];
  assign stage_d[0].msg = s_tdata[543:32];

  for (genvar k = 0; k < chacha_pkg::NUM_CELLS; k++) begin : g_cell
    localparam logic [2:0] PH = 3'(k % chacha_pkg::STEPS_PER_DR);
    chacha_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .phase     (PH),
      .in_valid  (stage_v[k]),
      .in_data   (stage_d[k]),
      .out_valid (stage_v[k+1]),
      .out_data  (stage_d[k+1])
    );
  end

  chacha_out u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (stage_v[chacha_pkg::NUM_CELLS]),
    .in_data   (stage_d[chacha_pkg::NUM_CELLS]),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked output");

  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_v[chacha_pkg::NUM_CELLS:1]))
    else $error("cell chain moved during a stall");

  a_chain_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> stage_v[1] == $past(s_tvalid))
    else $error("first cell lost or invented an item");

  a_out_from_chain: assert property (@(posedge clk) disable iff (rst)
    (en && !stage_v[chacha_pkg::NUM_CELLS]) |=> !m_tvalid)
    else $error("result without an item leaving the chain");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chacha20_block_cipher. Runs a directed table under
// the reset key and under a known key, then random 64-byte items under
// several keys and nonces, stalling both streams but in the last run. Every
// result item is checked field by field against a local ChaCha20 predictor.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0][63:0] msg;
    logic [31:0]      ctr;
  } item_t;

  localparam logic [2:0] REG_SPARE6   = 3'd6;
  localparam logic [2:0] REG_SPARE7   = 3'd7;
  localparam int         N_DIRECTED   = 12;
  localparam int         N_RANDOM     = 575;
  localparam int         DRAIN_CYCLES = 200;

  localparam logic [3:0][31:0] EXPAND_K = {
    32'h6b206574, 32'h79622d36, 32'h3320646e, 32'h61707865
  };

  // quarter-round lanes {a, b, c, d}: four columns, then four diagonals
  localparam logic [7:0][15:0] QR_LANES = {
    16'h349e, 16'h278d, 16'h16bc, 16'h05af,
    16'h37bf, 16'h26ae, 16'h159d, 16'h048c
  };

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [chacha_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [63:0]                       pwdata   = '0;
  logic [63:0]                       prdata;
  logic                              pready;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [543:0]                      s_tdata  = '0;  // block_counter, message_0..7
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [511:0]                      m_tdata;        // cipher_0..7

  logic [7:0][31:0]      key_w   = '0;
  logic [2:0][31:0]      nonce_w = '0;
  logic [511:0]          cipher_q [$];
  item_t                 dir_items [N_DIRECTED];
  int                    src_idle_pct = 0;
  int                    snk_idle_pct = 0;
  int                    mismatches   = 0;
  logic [7:0][63:0]      exp_c;
  logic [7:0][63:0]      got_c;

  chacha20_block_cipher u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
    a = a + b; d = rol32(d ^ a, 16);
    c = c + d; b = rol32(b ^ c, 12);
    a = a + b; d = rol32(d ^ a, 8);
    c = c + d; b = rol32(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  function automatic logic [511:0] chacha_xor(item_t it);
    logic [15:0][31:0] init;
    logic [15:0][31:0] x;
    logic [15:0]       ln;
    int                r;
    int                q;
    int                i;
    init = {nonce_w, it.ctr, key_w, EXPAND_K};
    x    = init;
    for (r = 0; r < chacha_pkg::DOUBLE_ROUNDS; r++) begin
      for (q = 0; q < 8; q++) begin
        ln = QR_LANES[q];
        {x[ln[15:12]], x[ln[11:8]], x[ln[7:4]], x[ln[3:0]]} =
          quarter(x[ln[15:12]], x[ln[11:8]], x[ln[7:4]], x[ln[3:0]]);
      end
    end
    for (i = 0; i < 16; i++) begin
      x[i] = x[i] + init[i];
    end
    return it.msg ^ x;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      chacha_pkg::REG_KEY01:   key_w[1:0] = val;
      chacha_pkg::REG_KEY23:   key_w[3:2] = val;
      chacha_pkg::REG_KEY45:   key_w[5:4] = val;
      chacha_pkg::REG_KEY67:   key_w[7:6] = val;
      chacha_pkg::REG_NONCE01: nonce_w[1:0] = val;
      chacha_pkg::REG_NONCE2:  nonce_w[2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [5:0][63:0] v);
    reg_write(chacha_pkg::REG_KEY01, v[0]);
    reg_write(chacha_pkg::REG_KEY23, v[1]);
    reg_write(chacha_pkg::REG_KEY45, v[2]);
    reg_write(chacha_pkg::REG_KEY67, v[3]);
    reg_write(chacha_pkg::REG_NONCE01, v[4]);
    reg_write(chacha_pkg::REG_NONCE2, v[5]);
  endtask

  task automatic send_block(item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    do @(posedge clk); while (!s_tready);
    cipher_q.push_back(chacha_xor(it));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n_items, int src_pct, int snk_pct);
    item_t       it;
    logic [31:0] next_ctr;
    int          k;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    next_ctr     = $urandom;
    repeat (n_items) begin
      // mostly a running counter, as a real stream would use it
      case ($urandom_range(9))
        0:       it.ctr = '1;
        1:       it.ctr = '0;
        2:       it.ctr = $urandom;
        default: it.ctr = next_ctr;
      endcase
      next_ctr = it.ctr + 32'd1;
      for (k = 0; k < 8; k++) begin
        it.msg[k] = rand64();
      end
      send_block(it);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_c = m_tdata;
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, got_c);
        mismatches++;
      end else begin
        exp_c = cipher_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (got_c[k] !== exp_c[k]) begin
            $display("%0t: cipher_%0d expected %h got %h", $time, k, exp_c[k], got_c[k]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("chacha20_block_cipher: mismatch");
    $finish;
  end

  initial begin
    logic [5:0][63:0] regs;
    int               i;
    dir_items = '{
      {512'h0, 32'h0000_0000},
      {512'h0, 32'h0000_0001},
      {512'h0, 32'hffff_ffff},
      {{512{1'b1}}, 32'hffff_ffff},
      {{512{1'b1}}, 32'h0000_0000},
      {{64{8'h55}}, 32'h8000_0000},
      {{64{8'haa}}, 32'h7fff_ffff},
      {{4{64'hffff_ffff_ffff_ffff, 64'h0}}, 32'h0000_0002},
      {512'h1, 32'hffff_fffe},
      {{1'b1, 511'h0}, 32'h0000_0003},
      {{8{64'h0123_4567_89ab_cdef}}, 32'ha5a5_a5a5},
      {{16{32'hdead_beef}}, 32'h5a5a_5a5a}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key and nonce
    for (i = 0; i < N_DIRECTED; i++) begin
      send_block(dir_items[i]);
    end
    drain();

    // known key; junk in the upper nonce word bits and in unused registers
    regs = {64'hffff_ffff_0000_0000, 64'h4a00_0000_0900_0000,
            64'h1f1e_1d1c_1b1a_1918, 64'h1716_1514_1312_1110,
            64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100};
    load_regs(regs);
    reg_write(REG_SPARE6, '1);
    reg_write(REG_SPARE7, '1);
    for (i = 0; i < N_DIRECTED; i++) begin
      send_block(dir_items[i]);
    end
    drain();

    load_regs('1);
    run_random(N_RANDOM, 32, 67);

    for (i = 0; i < 6; i++) begin
      regs[i] = rand64();
    end
    load_regs(regs);
    run_random(N_RANDOM, 67, 32);

    for (i = 0; i < 6; i++) begin
      regs[i] = rand64();
    end
    load_regs(regs);
    run_random(N_RANDOM, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("chacha20_block_cipher: match");
    end else begin
      $display("chacha20_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
